[rtl/mls_pkg.sv]
package mls_pkg;

  // Command carried with each word: tuser on the input stream.
  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  // Per-line orientation flags, set up by the front and held by the back.
  typedef struct packed {
    logic down;     // minor axis steps downward
    logic swapped;  // major axis is y
  } line_flags_t;

endpackage

[rtl/mls_front.sv]
module mls_front #(
  parameter int COORD_BITS = 11
) (
  input  mls_pkg::cmd_t                cmd,
  input  logic [COORD_BITS-1:0]        start_x,
  input  logic [COORD_BITS-1:0]        start_y,
  input  logic [COORD_BITS-1:0]        end_x,
  input  logic [COORD_BITS-1:0]        end_y,
  output logic [5*COORD_BITS+4:0]      entry
);

  localparam int CB = COORD_BITS;
  localparam logic [CB:0] ONE = {{CB{1'b0}}, 1'b1};

  logic [CB:0]   dx, dy, adx, ady;
  logic          swap;
  logic [CB:0]   dmaj, dmin;
  logic [CB-1:0] ps, qs, pe, qe;
  logic          down_pre;
  logic [CB:0]   span, delta;
  logic [CB-1:0] maj_start, min_start, maj_end;
  mls_pkg::line_flags_t flags;

  always_comb begin
    dx  = {1'b0, end_x} - {1'b0, start_x};
    dy  = {1'b0, end_y} - {1'b0, start_y};
    adx = dx[CB] ? ((~dx) + ONE) : dx;
    ady = dy[CB] ? ((~dy) + ONE) : dy;
    // y becomes the major axis only when strictly steeper
    swap = (adx < ady);

    dmaj     = swap ? dy : dx;
    dmin     = swap ? dx : dy;
    ps       = swap ? start_y : start_x;
    qs       = swap ? start_x : start_y;
    pe       = swap ? end_y : end_x;
    qe       = swap ? end_x : end_y;
    down_pre = swap ? (end_x < start_x) : (end_y < start_y);

    // order endpoints so the major coordinate increases
    if (dmaj[CB]) begin
      span          = (~dmaj) + ONE;
      delta         = (~dmin) + ONE;
      maj_start     = pe;
      min_start     = qe;
      maj_end       = ps;
      flags.down    = ~down_pre;
    end else begin
      span          = dmaj;
      delta         = dmin;
      maj_start     = ps;
      min_start     = qs;
      maj_end       = pe;
      flags.down    = down_pre;
    end
    flags.swapped = swap;

    entry = {flags, delta, span, maj_end, min_start, maj_start, cmd};
  end

endmodule

[rtl/mls_queue.sv]
module mls_queue #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [PW-1:0] PTR_ONE  = PW'(1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             push, pop;

  assign wr_ready = (count != FULL_CNT);
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_ONE;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_ONE;
      end
      if (push && !pop) begin
        count <= count + CNT_ONE;
      end else if (pop && !push) begin
        count <= count - CNT_ONE;
      end
    end
  end

endmodule

[rtl/mls_back.sv]
module mls_back #(
  parameter int COORD_BITS = 11
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  logic [5*COORD_BITS+4:0] q_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [COORD_BITS-1:0]   pixel_x,
  output logic [COORD_BITS-1:0]   pixel_y,
  output logic                    valid_res,
  output logic                    last
);

  localparam int CB = COORD_BITS;
  localparam logic [CB-1:0] POS_ONE = {{(CB-1){1'b0}}, 1'b1};

  // unpack queue word
  mls_pkg::cmd_t        e_cmd;
  logic [CB-1:0]        e_major, e_minor, e_end;
  logic [CB:0]          e_span, e_delta;
  mls_pkg::line_flags_t e_flags;

  assign e_cmd   = mls_pkg::cmd_t'(q_data[0]);
  assign e_major = q_data[CB:1];
  assign e_minor = q_data[2*CB:CB+1];
  assign e_end   = q_data[3*CB:2*CB+1];
  assign e_span  = q_data[4*CB+1:3*CB+1];
  assign e_delta = q_data[5*CB+2:4*CB+2];
  assign e_flags = mls_pkg::line_flags_t'(q_data[5*CB+4:5*CB+3]);

  // line state
  logic [CB-1:0]        major_pos, minor_pos, major_end;
  logic [CB:0]          major_span, minor_delta;
  logic [CB+2:0]        error_term;
  mls_pkg::line_flags_t flags;
  logic                 line_active;

  logic                 take, is_load, emit, is_last;
  logic [CB-1:0]        cur_major, cur_minor, cur_end;
  logic [CB:0]          cur_span, cur_delta;
  logic [CB+2:0]        cur_err;
  mls_pkg::line_flags_t cur_flags;
  logic [CB+3:0]        e4, d4, s4, test, acc;
  logic                 keep_minor;
  logic [CB-1:0]        minor_next;
  logic [CB+2:0]        error_next;

  assign q_ready = !out_valid || out_ready;
  assign take    = q_valid && q_ready;
  assign is_load = (e_cmd == mls_pkg::CMD_LOAD);
  assign emit    = is_load || line_active;

  always_comb begin
    cur_major = is_load ? e_major : major_pos;
    cur_minor = is_load ? e_minor : minor_pos;
    cur_end   = is_load ? e_end   : major_end;
    cur_span  = is_load ? e_span  : major_span;
    cur_delta = is_load ? e_delta : minor_delta;
    cur_err   = is_load ? '0      : error_term;
    cur_flags = is_load ? e_flags : flags;
    is_last   = (cur_major == cur_end);

    e4 = {cur_err[CB+2], cur_err};
    d4 = {{3{cur_delta[CB]}}, cur_delta};
    s4 = {3'b000, cur_span};

    // midpoint test, sign depends on minor direction
    if (!cur_flags.down) begin
      test       = e4 + e4 + d4 + d4 - s4;
      keep_minor = test[CB+3];
      acc        = keep_minor ? (e4 + d4) : (e4 + d4 - s4);
      minor_next = keep_minor ? cur_minor : cur_minor + POS_ONE;
    end else begin
      test       = e4 + e4 + d4 + d4 + s4;
      keep_minor = !test[CB+3] && (test != '0);
      acc        = keep_minor ? (e4 + d4) : (e4 + d4 + s4);
      minor_next = keep_minor ? cur_minor : cur_minor - POS_ONE;
    end
    error_next = acc[CB+2:0];
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      major_span  <= cur_span;
      minor_delta <= cur_delta;
      major_end   <= cur_end;
      flags       <= cur_flags;
      error_term  <= error_next;
      minor_pos   <= minor_next;
      major_pos   <= is_last ? cur_major : cur_major + POS_ONE;
    end
    if (take) begin
      if (emit) begin
        pixel_x <= cur_flags.swapped ? cur_minor : cur_major;
        pixel_y <= cur_flags.swapped ? cur_major : cur_minor;
      end else begin
        pixel_x <= '0;
        pixel_y <= '0;
      end
      valid_res <= emit;
      last      <= emit && is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (take && emit) begin
        line_active <= !is_last;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/midpoint_line_stepper.sv]
// Midpoint line stepper: an integer midpoint line rasterizer that emits one
// pixel per accepted input word. A word with tuser = 0 loads a line from its
// two endpoints and returns its first pixel; a word with tuser = 1 returns
// the next pixel, with tlast high on the final one. A step while no line is
// running returns a word with pixel data zero and the valid flag (tuser)
// low. Pixels run in order of increasing major coordinate, so a line may
// start at its second endpoint; with equal deltas x is the major axis.
// Throughput is one word per clock, loads included, while the output side
// does not stall: the front computes the endpoint setup in the accept cycle,
// and the back's combinational error update loop produces one pixel per clock.
// An accepted input word passes through a queue slot, then the output register,
// to its output word; the queue of QUEUE_DEPTH words lets the input side keep
// accepting during short output stalls.
module midpoint_line_stepper #(
  parameter int COORD_BITS  = 11,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // fields from bit 0 up: start_x, start_y, end_x, end_y
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]    s_tdata,
  // fields: mode (0 = load line, 1 = next pixel)
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // fields from bit 0 up: pixel_x, pixel_y
  output logic [((2*COORD_BITS+7)/8)*8-1:0]    m_tdata,
  // fields: valid_res
  output logic                                 m_tuser,
  output logic                                 m_tlast
);

  localparam int CB      = COORD_BITS;
  localparam int ENTRY_W = 5 * CB + 5;

  logic [ENTRY_W-1:0] front_entry, queue_entry;
  logic               q_valid, q_ready;
  logic [CB-1:0]      pixel_x, pixel_y;

  // classify the word and set up endpoints, axes and deltas
  mls_front #(
    .COORD_BITS(CB)
  ) u_front (
    .cmd     (mls_pkg::cmd_t'(s_tuser)),
    .start_x (s_tdata[CB-1:0]),
    .start_y (s_tdata[2*CB-1:CB]),
    .end_x   (s_tdata[3*CB-1:2*CB]),
    .end_y   (s_tdata[4*CB-1:3*CB]),
    .entry   (front_entry)
  );

  // decouple accept from pixel stepping
  mls_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (s_tvalid),
    .wr_ready (s_tready),
    .wr_data  (front_entry),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (queue_entry)
  );

  // hold line state, step the error term, register the output word
  mls_back #(
    .COORD_BITS(CB)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (queue_entry),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .valid_res (m_tuser),
    .last      (m_tlast)
  );

  // pack pixel coordinates, pad upper bits with zeros
  always_comb begin
    m_tdata            = '0;
    m_tdata[CB-1:0]    = pixel_x;
    m_tdata[2*CB-1:CB] = pixel_y;
  end

endmodule

[tb/midpoint_line_stepper_tb.sv]
`timescale 1ns / 100ps

module midpoint_line_stepper_tb;

  localparam int CW          = 11;
  localparam int S_BITS      = ((4*CW+7)/8)*8;
  localparam int M_BITS      = ((2*CW+7)/8)*8;
  localparam int COORD_MAX   = (1 << CW) - 1;
  localparam int WORD_COUNT  = 1725;
  localparam int STUCK_LIMIT = 2000;

  typedef struct {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          valid_res;
    logic          last;
  } pixel_t;

  // Tracks the line being drawn and holds the pixels the block owes us.
  class line_pixel_tracker;
    logic [CW-1:0]   major_pos;
    logic [CW-1:0]   minor_pos;
    logic [CW-1:0]   major_end;
    logic signed [11:0] major_span;
    logic signed [11:0] minor_delta;
    logic signed [13:0] err;
    logic            minor_down;
    logic            axes_swapped;
    logic            line_active;
    pixel_t          pixels_due[$];
    int              mismatches;

    function new();
      major_pos    = '0;
      minor_pos    = '0;
      major_end    = '0;
      major_span   = '0;
      minor_delta  = '0;
      err          = '0;
      minor_down   = 1'b0;
      axes_swapped = 1'b0;
      line_active  = 1'b0;
      mismatches   = 0;
    endfunction

    // Work out the pixel that an accepted input word must produce.
    function void take_word(mls_pkg::cmd_t cmd, logic [CW-1:0] sx, logic [CW-1:0] sy,
                            logic [CW-1:0] ex, logic [CW-1:0] ey);
      pixel_t p;
      int     x0, y0, x1, y1, dmaj, dmin, ps, qs, pe, t;
      bit     down, swapped;
      if (cmd == mls_pkg::CMD_LOAD) begin
        x0 = sx; y0 = sy; x1 = ex; y1 = ey;
        dmaj = x1 - x0;
        dmin = y1 - y0;
        ps = x0; qs = y0; pe = x1;
        down = (y1 < y0);
        swapped = 1'b0;
        // y takes over as major axis only on a strictly steeper line
        if (((dmaj < 0) ? -dmaj : dmaj) < ((dmin < 0) ? -dmin : dmin)) begin
          t = dmaj; dmaj = dmin; dmin = t;
          ps = y0; qs = x0; pe = y1;
          down = (x1 < x0);
          swapped = 1'b1;
        end
        // walk the major axis upward: start from the far endpoint if needed
        if (dmaj < 0) begin
          dmaj = -dmaj;
          dmin = -dmin;
          qs   = swapped ? x1 : y1;
          t = ps; ps = pe; pe = t;
          down = !down;
        end
        major_pos    = ps[CW-1:0];
        minor_pos    = qs[CW-1:0];
        major_end    = pe[CW-1:0];
        major_span   = dmaj[11:0];
        minor_delta  = dmin[11:0];
        err          = '0;
        minor_down   = down;
        axes_swapped = swapped;
        line_active  = 1'b1;
      end
      if (!line_active) begin
        // step with no line running: an empty word
        p.x = '0; p.y = '0; p.valid_res = 1'b0; p.last = 1'b0;
        pixels_due.push_back(p);
        return;
      end
      p.last      = (major_pos == major_end);
      p.x         = axes_swapped ? minor_pos : major_pos;
      p.y         = axes_swapped ? major_pos : minor_pos;
      p.valid_res = 1'b1;
      pixels_due.push_back(p);
      // midpoint test, mirrored for a falling minor axis
      if (!minor_down) begin
        if (2*int'(err) + 2*int'(minor_delta) - int'(major_span) < 0) begin
          err = err + minor_delta;
        end else begin
          err = err + minor_delta - major_span;
          minor_pos = minor_pos + 1'b1;
        end
      end else begin
        if (2*int'(err) + 2*int'(minor_delta) + int'(major_span) > 0) begin
          err = err + minor_delta;
        end else begin
          err = err + minor_delta + major_span;
          minor_pos = minor_pos - 1'b1;
        end
      end
      if (p.last) begin
        line_active = 1'b0;
      end else begin
        major_pos = major_pos + 1'b1;
      end
    endfunction

    // Compare an output word with the oldest pixel still owed.
    function void check_pixel(logic [CW-1:0] x, logic [CW-1:0] y,
                              logic valid_res, logic last);
      pixel_t e;
      if (pixels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: x=%0d y=%0d valid=%0b last=%0b",
                   x, y, valid_res, last);
        return;
      end
      e = pixels_due.pop_front();
      if (e.x !== x || e.y !== y || e.valid_res !== valid_res ||
          e.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel differs: exp x=%0d y=%0d v=%0b l=%0b, got x=%0d y=%0d v=%0b l=%0b",
                   e.x, e.y, e.valid_res, e.last, x, y, valid_res, last);
      end
    endfunction
  endclass

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [S_BITS-1:0] s_tdata  = '0;
  logic              s_tuser  = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [M_BITS-1:0] m_tdata;
  logic              m_tuser;
  logic              m_tlast;

  line_pixel_tracker tracker = new();
  int burst_left  = 0;
  int words_sent  = 0;
  int stuck_cycles = 0;

  midpoint_line_stepper u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Present one word at the falling edge and hold it until accepted. Words go
  // out in bursts of random length; a burst may be followed by an idle gap.
  task automatic send_word(mls_pkg::cmd_t cmd, logic [CW-1:0] sx, logic [CW-1:0] sy,
                           logic [CW-1:0] ex, logic [CW-1:0] ey);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {{(S_BITS-4*CW){1'b0}}, ey, ex, sy, sx};
    do @(posedge clk); while (!s_tready);
    tracker.take_word(cmd, sx, sy, ex, ey);
    burst_left--;
    words_sent++;
  endtask

  // Step words carry random coordinates; the block must ignore them.
  task automatic send_step();
    send_word(mls_pkg::CMD_STEP,
              CW'($urandom_range(0, COORD_MAX)), CW'($urandom_range(0, COORD_MAX)),
              CW'($urandom_range(0, COORD_MAX)), CW'($urandom_range(0, COORD_MAX)));
  endtask

  task automatic send_line(int sx, int sy, int ex, int ey, int steps);
    send_word(mls_pkg::CMD_LOAD, sx[CW-1:0], sy[CW-1:0], ex[CW-1:0], ey[CW-1:0]);
    repeat (steps) send_step();
  endtask

  // Hold the input side until every owed pixel has come out.
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (tracker.pixels_due.size() != 0) @(posedge clk);
  endtask

  // Offset along one axis, folded back if it would leave the coordinate range.
  function automatic int offset_coord(int c, int d);
    return (c + d >= 0 && c + d <= COORD_MAX) ? c + d : c - d;
  endfunction

  task automatic random_line();
    int r, span, sx, sy, ex, ey, dx, dy, adx, ady, steps;
    r    = $urandom_range(0, 99);
    span = (r < 70) ? $urandom_range(0, 12) :
           (r < 95) ? $urandom_range(13, 64) : $urandom_range(65, 300);
    sx = $urandom_range(0, COORD_MAX);
    sy = $urandom_range(0, COORD_MAX);
    dx = $urandom_range(0, span);
    dy = $urandom_range(0, span);
    if ($urandom_range(0, 1)) dx = -dx;
    if ($urandom_range(0, 1)) dy = -dy;
    // force equal deltas now and then
    if ($urandom_range(0, 7) == 0) dy = $urandom_range(0, 1) ? dx : -dx;
    ex  = offset_coord(sx, dx);
    ey  = offset_coord(sy, dy);
    adx = (ex > sx) ? ex - sx : sx - ex;
    ady = (ey > sy) ? ey - sy : sy - ey;
    steps = (adx > ady) ? adx : ady;
    // cut the line short sometimes so the next load drops it
    if ($urandom_range(0, 9) == 0) steps = $urandom_range(0, steps);
    send_line(sx, sy, ex, ey, steps);
    repeat ($urandom_range(0, 2)) send_step();
  endtask

  // Receiver: switch at random between stall styles after a run of random length.
  int rx_style = 0;
  int rx_left  = 0;
  int stall_left = 0;
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_style = $urandom_range(0, 3);
      rx_left  = $urandom_range(20, 200);
    end else begin
      rx_left--;
    end
    case (rx_style)
      0: begin
        m_tready <= 1'b1;
      end
      1: begin
        m_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        if (stall_left > 0) begin
          stall_left--;
          m_tready <= 1'b0;
        end else begin
          if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 30);
          m_tready <= 1'b1;
        end
      end
      default: begin
        m_tready <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  // Check every output word on the edge that accepts it.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      tracker.check_pixel(m_tdata[CW-1:0], m_tdata[2*CW-1:CW], m_tuser, m_tlast);
  end

  // Watchdog: end the run if neither side moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("midpoint_line_stepper: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int r;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed lines: idle step, single point, diagonal from corner to corner
    // dropped by a new load, a reversed shallow line at the top edge, a steep
    // reversed line, and a flat reversed line whose minor axis never moves.
    send_step();
    send_line(5, 5, 5, 5, 1);
    send_line(0, 0, COORD_MAX, COORD_MAX, 2);
    send_line(COORD_MAX, COORD_MAX, COORD_MAX - 7, COORD_MAX - 3, 7);
    send_line(10, COORD_MAX, 12, COORD_MAX - 4, 4);
    send_line(3, 0, 0, 0, 3);
    send_step();

    // Let the pipeline empty completely before the random part.
    wait_drained();

    while (words_sent < WORD_COUNT) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        random_line();
      end else if (r < 88) begin
        send_line($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                  $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                  $urandom_range(0, 20));
      end else if (r < 97) begin
        repeat ($urandom_range(1, 3)) send_step();
      end else begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pixels_due.size() == 0) begin
      $display("midpoint_line_stepper: match");
    end else begin
      $display("midpoint_line_stepper: mismatch");
    end
    $finish;
  end

endmodule
